/* hw/rtl/mcrg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrg_pkg
// Shared types and widths for the midpoint circle row generator.
// ----------------------------------------------------------------------------
package mcrg_pkg;

   localparam int unsigned COORD_W    = 5;  // loop offsets x and y
   localparam int unsigned DECISION_W = 8;  // signed midpoint decision

   // loop registers of the midpoint walk
   typedef struct packed {
      logic [COORD_W-1:0]           x;
      logic [COORD_W-1:0]           y;
      logic signed [DECISION_W-1:0] p;
   } loop_state_type;

   // result of one loop step
   typedef struct packed {
      loop_state_type nxt;    // state after the step
      logic           emits;  // the step yields rows
   } step_result_type;

endpackage

/* hw/rtl/mcrg_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrg_step
// One midpoint circle step: advances y, conditionally pulls x in, updates the
// decision and flags whether the step still produces rows.
// ----------------------------------------------------------------------------
module mcrg_step
   import mcrg_pkg::*;
(
   input  loop_state_type  cur,
   output step_result_type res
);

   logic                         keep_x;
   logic [COORD_W-1:0]           y_nxt;
   logic [COORD_W-1:0]           x_nxt;
   logic signed [DECISION_W-1:0] y_term;
   logic signed [DECISION_W-1:0] x_term;

   // decision update: p + 2y' + 1, minus 2x' when x moves in
   always_comb begin
      keep_x = (cur.p <= 0);
      y_nxt  = cur.y + COORD_W'(1);
      x_nxt  = keep_x ? cur.x : (cur.x - COORD_W'(1));
      y_term = $signed({{(DECISION_W-COORD_W-1){1'b0}}, y_nxt, 1'b1});
      x_term = keep_x ? '0 : $signed({{(DECISION_W-COORD_W-1){1'b0}}, x_nxt, 1'b0});
      res.nxt.x = x_nxt;
      res.nxt.y = y_nxt;
      res.nxt.p = cur.p + y_term - x_term;
      // loop runs while x > y and stops before emitting once x < y
      res.emits = (cur.x > cur.y) && (x_nxt >= y_nxt);
   end

endmodule

/* hw/rtl/midpoint_circle_row_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_row_generator
// Turns a circle request into raster rows with the integer midpoint loop.
// First row: a request beat loads ST_CTR, which registers the centre row.
// Throughput: one row per cycle while rsp_tready allows; a new request is accepted
// only once the sequencer has returned to idle after the last row of a circle.
// Reset: synchronous, clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module midpoint_circle_row_generator
   import mcrg_pkg::*;
#(
   parameter int unsigned MAX_RADIUS = 15
)
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // center_x[5:0], center_y[10:6], radius[14:11],
                                    // color[38:15], zero pad[39]
   input  logic        req_tuser,   // filled
   // row channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // row_y[6:0], left_x[14:7], right_x[22:15],
                                    // pixel_color[46:23], zero pad[47]
   output logic        rsp_tuser,   // solid
   output logic        rsp_tlast    // last
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CTR, ST_TOP, ST_BOT, ST_ROW0, ST_ROW1, ST_ROW2, ST_ROW3
   } seq_state_type;

   localparam logic [3:0] RADIUS_CAP = 4'(MAX_RADIUS);

   seq_state_type     state_ff, state_in;
   loop_state_type    loop_ff, loop_in;
   step_result_type   step;
   logic [5:0]        cx_ff, cx_in;
   logic [4:0]        cy_ff, cy_in;
   logic              fill_ff, fill_in;
   logic [23:0]       color_ff, color_in;
   logic              out_valid_ff, out_valid_in;
   logic signed [6:0] out_y_ff, out_y_in;
   logic signed [7:0] out_l_ff, out_l_in;
   logic signed [7:0] out_r_ff, out_r_in;
   logic              out_solid_ff, out_solid_in;
   logic [23:0]       out_color_ff, out_color_in;
   logic              out_last_ff, out_last_in;

   logic [3:0]        radius_sat;
   logic              advance;
   logic              group_end;
   logic signed [6:0] cy_s, yo_s, xo_s;
   logic signed [7:0] cx_s, xo_w, yo_w;
   logic signed [6:0] row_y;
   logic signed [7:0] row_l, row_r;
   logic              row_solid;

   // shared step unit
   mcrg_step u_step (
      .cur (loop_ff),
      .res (step)
   );

   assign radius_sat = (req_tdata[14:11] > RADIUS_CAP) ? RADIUS_CAP : req_tdata[14:11];
   assign req_tready = (state_ff == ST_IDLE);
   assign advance    = (state_ff != ST_IDLE) && (!out_valid_ff || rsp_tready);

   // widened operands for row arithmetic
   assign cy_s = $signed({2'b00, cy_ff});
   assign yo_s = $signed({2'b00, loop_ff.y});
   assign xo_s = $signed({2'b00, loop_ff.x});
   assign cx_s = $signed({2'b00, cx_ff});
   assign xo_w = $signed({3'b000, loop_ff.x});
   assign yo_w = $signed({3'b000, loop_ff.y});

   // row of the current phase
   always_comb begin
      row_y     = cy_s;
      row_l     = cx_s - xo_w;
      row_r     = cx_s + xo_w;
      row_solid = fill_ff;
      group_end = 1'b0;
      case (state_ff)
         ST_CTR: begin
            group_end = fill_ff || (loop_ff.x == '0);
         end
         ST_TOP: begin
            row_y     = cy_s - xo_s;
            row_l     = cx_s;
            row_r     = cx_s;
            row_solid = 1'b0;
         end
         ST_BOT: begin
            row_y     = cy_s + xo_s;
            row_l     = cx_s;
            row_r     = cx_s;
            row_solid = 1'b0;
            group_end = 1'b1;
         end
         ST_ROW0: begin
            row_y = cy_s + yo_s;
         end
         ST_ROW1: begin
            row_y     = cy_s - yo_s;
            group_end = (loop_ff.x == loop_ff.y);
         end
         ST_ROW2: begin
            row_y = cy_s + xo_s;
            row_l = cx_s - yo_w;
            row_r = cx_s + yo_w;
         end
         ST_ROW3: begin
            row_y     = cy_s - xo_s;
            row_l     = cx_s - yo_w;
            row_r     = cx_s + yo_w;
            group_end = 1'b1;
         end
         default: begin
            group_end = 1'b0;
         end
      endcase
   end

   // sequencer and output register next values
   always_comb begin
      state_in     = state_ff;
      loop_in      = loop_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      fill_in      = fill_ff;
      color_in     = color_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_y_in     = out_y_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      out_solid_in = out_solid_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;

      if (state_ff == ST_IDLE) begin
         if (req_tvalid) begin
            cx_in     = req_tdata[5:0];
            cy_in     = req_tdata[10:6];
            color_in  = req_tdata[38:15];
            fill_in   = req_tuser;
            loop_in.x = {1'b0, radius_sat};
            loop_in.y = '0;
            loop_in.p = 8'sd1 - $signed({4'b0000, radius_sat});
            state_in  = ST_CTR;
         end
      end else if (advance) begin
         out_valid_in = 1'b1;
         out_y_in     = row_y;
         out_l_in     = row_l;
         out_r_in     = row_r;
         out_solid_in = row_solid;
         out_color_in = color_ff;
         out_last_in  = group_end && !step.emits;
         if (group_end) begin
            if (step.emits) begin
               loop_in  = step.nxt;
               state_in = ST_ROW0;
            end else begin
               state_in = ST_IDLE;
            end
         end else begin
            case (state_ff)
               ST_CTR:  state_in = ST_TOP;
               ST_TOP:  state_in = ST_BOT;
               ST_ROW0: state_in = ST_ROW1;
               ST_ROW1: state_in = ST_ROW2;
               ST_ROW2: state_in = ST_ROW3;
               default: state_in = ST_IDLE;
            endcase
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         loop_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         loop_ff      <= loop_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      fill_ff      <= fill_in;
      color_ff     <= color_in;
      out_y_ff     <= out_y_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
      out_solid_ff <= out_solid_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_color_ff, out_r_ff, out_l_ff, out_y_ff};
   assign rsp_tuser  = out_solid_ff;
   assign rsp_tlast  = out_last_ff;

   // a request beat makes the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted but sequencer still idle");

   // while rows of a step go out the walk has not crossed the diagonal
   a_loop_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW0 || state_ff == ST_ROW1 || state_ff == ST_ROW2 ||
       state_ff == ST_ROW3) |-> (loop_ff.x >= loop_ff.y))
      else $error("loop x below y while emitting rows");

   // a pending final row means the circle is done
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (state_ff == ST_IDLE || state_ff == ST_CTR))
      else $error("final row pending while circle still in progress");

endmodule
